// ===== rtl/core/keyword_token_lexer_unit_assert.svh =====
// Assertion macros for the lexer; clock and reset are the top level's clk and arst_n.
`ifndef KEYWORD_TOKEN_LEXER_UNIT_ASSERT_SVH
`define KEYWORD_TOKEN_LEXER_UNIT_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define KWL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define KWL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/kwl_pkg.sv =====
`timescale 1ns / 1ps
package kwl_pkg;

	localparam int POS_BITS = 32;
	localparam int LEN_BITS = 16;
	localparam int KIND_W   = 5;
	localparam int ERR_W    = 2;

	// Queue between the scanner and the output stage
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Token kinds
	localparam logic [KIND_W-1:0] K_EXIT    = 5'd0;
	localparam logic [KIND_W-1:0] K_WRITELN = 5'd1;
	localparam logic [KIND_W-1:0] K_MUT     = 5'd2;
	localparam logic [KIND_W-1:0] K_CONST   = 5'd3;
	localparam logic [KIND_W-1:0] K_TRUE    = 5'd4;
	localparam logic [KIND_W-1:0] K_FALSE   = 5'd5;
	localparam logic [KIND_W-1:0] K_USEIO   = 5'd6;
	localparam logic [KIND_W-1:0] K_IDENT   = 5'd7;
	localparam logic [KIND_W-1:0] K_INT     = 5'd8;
	localparam logic [KIND_W-1:0] K_FLOAT   = 5'd9;
	localparam logic [KIND_W-1:0] K_SEMI    = 5'd10;
	localparam logic [KIND_W-1:0] K_LPAREN  = 5'd11;
	localparam logic [KIND_W-1:0] K_RPAREN  = 5'd12;
	localparam logic [KIND_W-1:0] K_PLUS    = 5'd13;
	localparam logic [KIND_W-1:0] K_MINUS   = 5'd14;
	localparam logic [KIND_W-1:0] K_STAR    = 5'd15;
	localparam logic [KIND_W-1:0] K_SLASH   = 5'd16;
	localparam logic [KIND_W-1:0] K_LESS    = 5'd17;
	localparam logic [KIND_W-1:0] K_GREATER = 5'd18;
	localparam logic [KIND_W-1:0] K_QMARK   = 5'd19;
	localparam logic [KIND_W-1:0] K_EQUAL   = 5'd20;
	localparam logic [KIND_W-1:0] K_ASSIGN  = 5'd21;
	localparam logic [KIND_W-1:0] K_NOTEQ   = 5'd22;
	localparam logic [KIND_W-1:0] K_QUOTE   = 5'd23;
	localparam logic [KIND_W-1:0] K_STRING  = 5'd24;

	// Error codes
	localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
	localparam logic [ERR_W-1:0] ERR_SYMBOL = 2'd1;
	localparam logic [ERR_W-1:0] ERR_QUOTE  = 2'd2;

	// Scanner modes
	typedef enum logic [3:0] {
		M_IDLE,
		M_WORD,
		M_USE_GAP,
		M_FOLLOW,
		M_NUM,
		M_EQ,
		M_BANG,
		M_STR,
		M_HALT,
		M_DONE
	} mode_t;

	// One result item
	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [POS_BITS-1:0] start;
		logic [LEN_BITS-1:0] len;
		logic [ERR_W-1:0]    err;
		logic                last;
	} tok_t;

	// Up to two results from one byte, oldest in t0
	typedef struct packed {
		logic v0;
		logic v1;
		tok_t t0;
		tok_t t1;
	} res_pair_t;

	// Queue status seen by the scanner and the output stage
	typedef struct packed {
		logic              empty;
		logic              room2;
		logic [QCNT_W-1:0] count;
	} q_stat_t;

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return b == " " || (b >= 8'd9 && b <= 8'd13);
	endfunction

endpackage

// ===== rtl/core/kwl_front.sv =====
`timescale 1ns / 1ps
module kwl_front import kwl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  logic [7:0] char_byte,
	input  logic      end_of_input,
	output res_pair_t res
);

	// Keyword table; the last row is "use"
	localparam int NKW    = 7;
	localparam int KW_USE = 6;
	localparam logic [7:0] KW_TEXT [NKW][7] = '{
		'{"e", "x", "i", "t", 8'h00, 8'h00, 8'h00},
		'{"w", "r", "i", "t", "e", "l", "n"},
		'{"m", "u", "t", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"c", "o", "n", "s", "t", 8'h00, 8'h00},
		'{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00},
		'{"f", "a", "l", "s", "e", 8'h00, 8'h00},
		'{"u", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00}
	};
	localparam logic [2:0] KW_LEN [NKW] = '{3'd4, 3'd7, 3'd3, 3'd5, 3'd4, 3'd5, 3'd3};
	localparam logic [KIND_W-1:0] KW_KIND [NKW] = '{
		K_EXIT, K_WRITELN, K_MUT, K_CONST, K_TRUE, K_FALSE, K_IDENT
	};

	localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

	mode_t               mode_q, mode_d;
	logic [7:0]          word_q [7];
	logic [7:0]          word_d [7];
	logic [LEN_BITS-1:0] len_q, len_d;
	logic [7:0]          follow_q [2];
	logic [7:0]          follow_d [2];
	logic [1:0]          flen_q, flen_d;
	logic                dot_q, dot_d;
	logic [POS_BITS-1:0] start_q, start_d;
	logic [POS_BITS-1:0] pos_q, pos_d;

	logic                fin;
	logic                alpha;
	logic                space;
	logic                num_start;
	logic                cont;
	logic                restart;
	logic [NKW-1:0]      kw_hit;
	logic [KIND_W-1:0]   word_kind;
	logic                is_use;
	logic                is_io;
	logic [LEN_BITS-1:0] len_inc;
	logic [1:0]          flen_inc;

	mode_t               st_mode;
	logic                st_emit;
	logic [KIND_W-1:0]   st_kind;
	logic [ERR_W-1:0]    st_err;

	// Classify the input byte
	assign fin       = end_of_input || (char_byte == 8'h00);
	assign alpha     = !fin && is_alpha(char_byte);
	assign space     = is_space(char_byte);
	assign num_start = is_digit(char_byte) || (char_byte == ".");
	assign len_inc   = (len_q != LEN_MAX) ? len_q + LEN_BITS'(1) : len_q;
	assign flen_inc  = (flen_q != 2'd3) ? flen_q + 2'd1 : flen_q;
	assign is_io     = (flen_q == 2'd2) && (follow_q[0] == "i") && (follow_q[1] == "o");

	// Match the buffered word against every keyword in parallel
	always_comb begin
		kw_hit = '0;
		for (int k = 0; k < NKW; k++) begin
			kw_hit[k] = (len_q == LEN_BITS'(KW_LEN[k]));
			for (int i = 0; i < 7; i++) begin
				if (i < int'(KW_LEN[k]) && word_q[i] != KW_TEXT[k][i])
					kw_hit[k] = 1'b0;
			end
		end
	end

	always_comb begin
		word_kind = K_IDENT;
		for (int k = 0; k < NKW; k++) begin
			if (kw_hit[k])
				word_kind = KW_KIND[k];
		end
	end

	assign is_use = kw_hit[KW_USE];

	// Decode the byte as the first byte of a new token
	always_comb begin
		st_mode = M_IDLE;
		st_emit = 1'b0;
		st_kind = K_EXIT;
		st_err  = ERR_NONE;
		if (fin) begin
			st_mode = M_DONE;
		end else if (space) begin
			st_mode = M_IDLE;
		end else if (is_alpha(char_byte)) begin
			st_mode = M_WORD;
		end else if (num_start) begin
			st_mode = M_NUM;
		end else begin
			case (char_byte)
				";": begin st_emit = 1'b1; st_kind = K_SEMI; end
				"(": begin st_emit = 1'b1; st_kind = K_LPAREN; end
				")": begin st_emit = 1'b1; st_kind = K_RPAREN; end
				"+": begin st_emit = 1'b1; st_kind = K_PLUS; end
				"-": begin st_emit = 1'b1; st_kind = K_MINUS; end
				"*": begin st_emit = 1'b1; st_kind = K_STAR; end
				"/": begin st_emit = 1'b1; st_kind = K_SLASH; end
				"<": begin st_emit = 1'b1; st_kind = K_LESS; end
				">": begin st_emit = 1'b1; st_kind = K_GREATER; end
				"?": begin st_emit = 1'b1; st_kind = K_QMARK; end
				"=": st_mode = M_EQ;
				"!": st_mode = M_BANG;
				"\"": begin
					st_emit = 1'b1;
					st_kind = K_QUOTE;
					st_mode = M_STR;
				end
				default: begin
					st_emit = 1'b1;
					st_err  = ERR_SYMBOL;
					st_mode = M_HALT;
				end
			endcase
		end
	end

	// Decide whether the byte continues the current token or restarts the scan
	always_comb begin
		cont    = 1'b0;
		restart = 1'b0;
		case (mode_q)
			M_IDLE:    restart = 1'b1;
			M_WORD: begin
				cont    = alpha;
				restart = !alpha && !is_use;
			end
			M_USE_GAP: begin
				cont    = alpha;
				restart = !alpha;
			end
			M_FOLLOW: begin
				cont    = alpha;
				restart = !alpha;
			end
			M_NUM: begin
				cont    = !fin && (is_digit(char_byte) || (char_byte == "." && !dot_q));
				restart = !cont;
			end
			M_EQ, M_BANG: begin
				cont    = !fin && (char_byte == "=");
				restart = !cont;
			end
			M_STR:     cont = !fin && (char_byte != "\"");
			default:   ;
		endcase
	end

	// Next state
	always_comb begin
		mode_d   = mode_q;
		word_d   = word_q;
		len_d    = len_q;
		follow_d = follow_q;
		flen_d   = flen_q;
		dot_d    = dot_q;
		start_d  = start_q;
		pos_d    = pos_q;
		case (mode_q)
			M_WORD: begin
				if (cont) begin
					if (len_q < LEN_BITS'(7))
						word_d[len_q[2:0]] = char_byte;
					len_d = len_inc;
				end else if (is_use) begin
					mode_d = fin ? M_DONE : M_USE_GAP;
				end
			end
			M_USE_GAP: begin
				if (cont) begin
					follow_d[0] = char_byte;
					flen_d      = 2'd1;
					mode_d      = M_FOLLOW;
				end
			end
			M_FOLLOW: begin
				if (cont) begin
					if (flen_q < 2'd2)
						follow_d[flen_q[0]] = char_byte;
					flen_d = flen_inc;
				end
			end
			M_NUM: begin
				if (cont) begin
					if (char_byte == ".")
						dot_d = 1'b1;
					len_d = len_inc;
				end
			end
			M_EQ, M_BANG: begin
				if (cont)
					mode_d = M_IDLE;
			end
			M_STR: begin
				if (fin)
					mode_d = M_HALT;
				else if (cont)
					len_d = len_inc;
				else
					mode_d = M_IDLE;
			end
			M_IDLE, M_HALT, M_DONE: ;
			default: mode_d = M_HALT;
		endcase
		// Start a new token from this byte
		if (restart) begin
			mode_d = st_mode;
			if (!fin && !space) begin
				start_d = pos_q;
				if (is_alpha(char_byte)) begin
					word_d[0] = char_byte;
					len_d     = LEN_BITS'(1);
				end else if (num_start) begin
					dot_d = (char_byte == ".");
					len_d = LEN_BITS'(1);
				end else if (char_byte == "\"") begin
					start_d = pos_q + POS_BITS'(1);
					len_d   = '0;
				end
			end
		end
		// Count consumed bytes while running
		if (!fin && mode_q != M_HALT && mode_q != M_DONE)
			pos_d = pos_q + POS_BITS'(1);
	end

	// Results
	always_comb begin
		res    = '0;
		res.t0 = '{kind: K_IDENT, start: start_q, len: LEN_BITS'(3), err: ERR_NONE, last: 1'b0};
		res.t1 = '{kind: K_QUOTE, start: pos_q, len: LEN_BITS'(1), err: ERR_NONE, last: 1'b0};
		case (mode_q)
			M_WORD: begin
				if (!cont) begin
					if (is_use) begin
						res.v0 = fin;
					end else begin
						res.v0      = 1'b1;
						res.t0.kind = word_kind;
						res.t0.len  = len_q;
					end
				end
			end
			M_USE_GAP: res.v0 = !cont;
			M_FOLLOW: begin
				if (!cont) begin
					res.v0 = 1'b1;
					if (is_io) begin
						res.t0.kind = K_USEIO;
						res.t0.len  = LEN_BITS'(6);
					end
				end
			end
			M_NUM: begin
				if (!cont) begin
					res.v0      = 1'b1;
					res.t0.kind = dot_q ? K_FLOAT : K_INT;
					res.t0.len  = len_q;
				end
			end
			M_EQ: begin
				res.v0      = 1'b1;
				res.t0.kind = cont ? K_EQUAL : K_ASSIGN;
				res.t0.len  = cont ? LEN_BITS'(2) : LEN_BITS'(1);
			end
			M_BANG: begin
				res.v0      = cont;
				res.t0.kind = K_NOTEQ;
				res.t0.len  = LEN_BITS'(2);
			end
			M_STR: begin
				if (fin) begin
					res.v0       = 1'b1;
					res.t0.kind  = K_EXIT;
					res.t0.start = pos_q;
					res.t0.len   = '0;
					res.t0.err   = ERR_QUOTE;
				end else if (!cont) begin
					res.v0      = 1'b1;
					res.v1      = 1'b1;
					res.t0.kind = K_STRING;
					res.t0.len  = len_q;
				end
			end
			default: ;
		endcase
		// Append the result of the restarted token
		if (restart && st_emit) begin
			if (res.v0) begin
				res.v1      = 1'b1;
				res.t1.kind = st_kind;
				res.t1.err  = st_err;
			end else begin
				res.v0       = 1'b1;
				res.t0.kind  = st_kind;
				res.t0.start = pos_q;
				res.t0.len   = LEN_BITS'(1);
				res.t0.err   = st_err;
			end
		end
		// Mark the last result of this byte
		res.t1.last = res.v1;
		res.t0.last = res.v0 && !res.v1;
		res.v0      = res.v0 && accept;
		res.v1      = res.v1 && accept;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			len_q   <= '0;
			flen_q  <= '0;
			dot_q   <= 1'b0;
			start_q <= '0;
			pos_q   <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			len_q   <= len_d;
			flen_q  <= flen_d;
			dot_q   <= dot_d;
			start_q <= start_d;
			pos_q   <= pos_d;
		end
	end

	// Word and follow-word letters
	always_ff @(posedge clk) begin
		if (accept) begin
			word_q   <= word_d;
			follow_q <= follow_d;
		end
	end

endmodule

// ===== rtl/core/kwl_queue.sv =====
`timescale 1ns / 1ps
module kwl_queue import kwl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  res_pair_t wr,
	input  logic      rd,
	output tok_t      rd_data,
	output q_stat_t   stat
);

	tok_t              mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic [QCNT_W-1:0] n_wr;

	assign n_wr         = QCNT_W'(wr.v0) + QCNT_W'(wr.v1);
	assign rd_data      = mem[rd_ptr_q];
	assign stat.empty   = (count_q == '0);
	assign stat.room2   = (count_q <= QCNT_W'(QDEPTH - 2));
	assign stat.count   = count_q;

	// Write up to two entries in order
	always_ff @(posedge clk) begin
		if (wr.v0)
			mem[wr_ptr_q] <= wr.t0;
		if (wr.v1)
			mem[wr_ptr_q + QPTR_W'(1)] <= wr.t1;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(n_wr);
			if (rd)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			count_q <= count_q + n_wr - QCNT_W'(rd);
		end
	end

endmodule

// ===== rtl/core/kwl_back.sv =====
`timescale 1ns / 1ps
module kwl_back import kwl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_stat_t q_stat,
	input  tok_t    q_data,
	output logic    q_rd,
	input  logic    pop,
	output logic    empty,
	output tok_t    tok
);

	logic valid_q;
	tok_t tok_q;

	// Load the next result when the register is free or being drained
	assign q_rd  = !q_stat.empty && (!valid_q || pop);
	assign empty = !valid_q;
	assign tok   = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_rd) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd)
			tok_q <= q_data;
	end

endmodule

// ===== rtl/core/keyword_token_lexer_unit.sv =====
`timescale 1ns / 1ps
// Channel  | Handshake         | Payload
// ---------+-------------------+-----------------------------------------------------------
// bytes in | push / full       | char_byte, end_of_input
// tokens   | pop / empty       | token_kind, start_pos, token_length, error_code, last_of_run
//
// One byte is taken per cycle while full is low; the scanner state registers close the loop.
// A byte's results enter the token queue, then the output register once free or popped.
// full is high while the four-entry token queue cannot take two more results.
// A stalled pop fills the queue and then holds full; the output register keeps its token.
// arst_n clears the scanner, queue pointers and output valid; no clearing pass is needed.
`include "keyword_token_lexer_unit_assert.svh"
module keyword_token_lexer_unit import kwl_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [7:0]          char_byte,
	input  logic                end_of_input,
	output logic                empty,
	input  logic                pop,
	output logic [KIND_W-1:0]   token_kind,
	output logic [POS_BITS-1:0] start_pos,
	output logic [LEN_BITS-1:0] token_length,
	output logic [ERR_W-1:0]    error_code,
	output logic                last_of_run
);

	logic      accept;
	res_pair_t res;
	q_stat_t   q_stat;
	tok_t      q_data;
	logic      q_rd;
	tok_t      tok;

	// Take a byte only when the queue has room for both possible results
	assign full   = !q_stat.room2;
	assign accept = push && !full;

	kwl_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.char_byte    (char_byte),
		.end_of_input (end_of_input),
		.res          (res)
	);

	kwl_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (res),
		.rd      (q_rd),
		.rd_data (q_data),
		.stat    (q_stat)
	);

	kwl_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.q_data (q_data),
		.q_rd   (q_rd),
		.pop    (pop),
		.empty  (empty),
		.tok    (tok)
	);

	assign token_kind   = tok.kind;
	assign start_pos    = tok.start;
	assign token_length = tok.len;
	assign error_code   = tok.err;
	assign last_of_run  = tok.last;

	// Queue never overfills
	`KWL_ASSERT_NOW(a_queue_bound, 1'b1, q_stat.count <= QCNT_W'(QDEPTH), "token queue overflow")
	// A second result only comes with a first
	`KWL_ASSERT_NOW(a_pair_order, res.v1, res.v0 && !res.t0.last && res.t1.last, "bad result pair")
	// A lone result closes its byte's run
	`KWL_ASSERT_NOW(a_single_last, res.v0 && !res.v1, res.t0.last, "single result not last")
	// After an error the scanner stays silent
	`KWL_ASSERT_NEXT(a_halt_after_err, res.v0 && res.t0.err != ERR_NONE, !res.v0 && !res.v1,
		"result after error")

endmodule
